[rtl/core/bba_pkg.sv]
// Shared types and constants for the LED-strip bubble animator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int COLOR_W   = 24;
  localparam int DICE_W    = 7;
  localparam int POS_W     = 11;  // bubble position, signed
  localparam int EXT_W     = 12;  // headroom for span and gap arithmetic
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;
  localparam int PCOUNT_W  = 9;

  localparam logic signed [POS_W-1:0] POS_MIN     = -11'sd1024;
  localparam logic signed [POS_W-1:0] POS_MAX     = 11'sd1023;
  localparam logic signed [POS_W-1:0] LEAD_RESET  = -11'sd10;
  localparam logic signed [POS_W-1:0] TRAIL_RESET = 11'sd266;  // reset count plus ten

  localparam logic [PCOUNT_W-1:0] PIXEL_COUNT_RESET = 9'd256;

  // dice codes that pick a background colour; anything else keeps the stored one
  localparam logic [DICE_W-1:0] DICE_BG0 = 7'd0;
  localparam logic [DICE_W-1:0] DICE_BG1 = 7'd1;
  localparam logic [DICE_W-1:0] DICE_BG2 = 7'd2;

  typedef enum logic [2:0] {
    REG_PIXEL_COUNT = 3'd0,
    REG_MIDPOINT    = 3'd1,
    REG_BUBBLE_W    = 3'd2,
    REG_BUBBLE_SPD  = 3'd3,
    REG_TRAIL_MODE  = 3'd4,
    REG_BUBBLE_COL  = 3'd5,
    REG_BG_ZERO     = 3'd6,
    REG_BG_ONE_TWO  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PCOUNT_W-1:0]  pixel_count;
    logic [7:0]           midpoint;
    logic [7:0]           bubble_width;
    logic [7:0]           bubble_speed;
    logic                 trail_mode;
    logic [COLOR_W-1:0]   bubble_color;
    logic [COLOR_W-1:0]   background_color_zero;
    logic [2*COLOR_W-1:0] background_colors_one_two;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] lead;
    logic signed [POS_W-1:0] trail;
  } pos_t;

endpackage

`default_nettype wire

[rtl/core/bba_regs.sv]
// APB-style configuration registers of the bubble animator.
// Depends on bba_pkg for the register map and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module bba_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bba_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bba_pkg::DATA_W-1:0]  pwdata,
  output logic      [bba_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output bba_pkg::cfg_t                    cfg
);
  import bba_pkg::*;

  reg_idx_t sel;
  logic     wr;

  // registers sit on 8-byte boundaries
  assign sel    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_count               <= PIXEL_COUNT_RESET;
      cfg.midpoint                  <= 8'd128;
      cfg.bubble_width              <= 8'd4;
      cfg.bubble_speed              <= 8'd1;
      cfg.trail_mode                <= 1'b0;
      cfg.bubble_color              <= 24'hFFFFFF;
      cfg.background_color_zero     <= '0;
      cfg.background_colors_one_two <= '0;
    end else if (wr) begin
      case (sel)
        REG_PIXEL_COUNT: cfg.pixel_count               <= pwdata[PCOUNT_W-1:0];
        REG_MIDPOINT:    cfg.midpoint                  <= pwdata[7:0];
        REG_BUBBLE_W:    cfg.bubble_width              <= pwdata[7:0];
        REG_BUBBLE_SPD:  cfg.bubble_speed              <= pwdata[7:0];
        REG_TRAIL_MODE:  cfg.trail_mode                <= pwdata[0];
        REG_BUBBLE_COL:  cfg.bubble_color              <= pwdata[COLOR_W-1:0];
        REG_BG_ZERO:     cfg.background_color_zero     <= pwdata[COLOR_W-1:0];
        REG_BG_ONE_TWO:  cfg.background_colors_one_two <= pwdata[2*COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_PIXEL_COUNT: prdata = DATA_W'(cfg.pixel_count);
      REG_MIDPOINT:    prdata = DATA_W'(cfg.midpoint);
      REG_BUBBLE_W:    prdata = DATA_W'(cfg.bubble_width);
      REG_BUBBLE_SPD:  prdata = DATA_W'(cfg.bubble_speed);
      REG_TRAIL_MODE:  prdata = DATA_W'(cfg.trail_mode);
      REG_BUBBLE_COL:  prdata = DATA_W'(cfg.bubble_color);
      REG_BG_ZERO:     prdata = DATA_W'(cfg.background_color_zero);
      REG_BG_ONE_TWO:  prdata = DATA_W'(cfg.background_colors_one_two);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/bba_sequencer.sv]
// Pixel counter and bubble positions; steps once per accepted transfer.
// Depends on bba_pkg for cfg_t, pos_t and position limits.
`timescale 1ns / 1ps
`default_nettype none

module bba_sequencer #(
  parameter int MAX_PIXELS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  bba_pkg::cfg_t                      cfg,
  input  wire logic                          accept,
  input  wire logic                          step_seen,
  output logic [$clog2(MAX_PIXELS)-1:0]      idx,
  output bba_pkg::pos_t                      pos,
  output logic                               last
);
  import bba_pkg::*;

  localparam int IW    = $clog2(MAX_PIXELS);
  localparam int CW    = $clog2(MAX_PIXELS + 1);
  localparam int CMP_W = (CW > PCOUNT_W) ? CW : PCOUNT_W;

  logic [IW-1:0]            counter, counter_next;
  pos_t                     cur, cur_next;
  logic [CMP_W-1:0]         pc_w, count_w;
  logic [CW-1:0]            count, idx_inc;
  logic                     restart, move;
  logic signed [EXT_W-1:0]  spd, lead_sub, trail_add, count_s;
  logic signed [POS_W-1:0]  mid_s;

  // effective count: zero acts as one, clamp at the store depth
  always_comb begin
    pc_w = CMP_W'(cfg.pixel_count);
    if (pc_w == '0) begin
      count_w = CMP_W'(1);
    end else if (pc_w > CMP_W'(MAX_PIXELS)) begin
      count_w = CMP_W'(MAX_PIXELS);
    end else begin
      count_w = pc_w;
    end
    count = CW'(count_w);
  end

  always_comb begin
    idx     = (CW'(counter) >= count) ? '0 : counter;
    idx_inc = CW'(idx) + CW'(1);
    last    = (idx_inc >= count);
    counter_next = last ? '0 : IW'(idx_inc);

    mid_s   = $signed({{(POS_W-8){1'b0}}, cfg.midpoint});
    restart = (idx == '0) && step_seen;
    pos     = cur;
    if (restart) begin
      pos.lead  = mid_s;
      pos.trail = mid_s + POS_W'(1);
    end

    spd       = $signed({{(EXT_W-8){1'b0}}, cfg.bubble_speed});
    count_s   = $signed(EXT_W'(count));
    lead_sub  = EXT_W'($signed(pos.lead)) - spd;
    trail_add = EXT_W'($signed(pos.trail)) + spd;
    move      = last && (($signed(pos.lead) >= 0) ||
                         (EXT_W'($signed(pos.trail)) <= count_s));

    cur_next = pos;
    if (move) begin
      cur_next.lead  = (lead_sub < EXT_W'(POS_MIN)) ? POS_MIN : POS_W'(lead_sub);
      cur_next.trail = (trail_add > EXT_W'(POS_MAX)) ? POS_MAX : POS_W'(trail_add);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter   <= '0;
      cur.lead  <= LEAD_RESET;
      cur.trail <= TRAIL_RESET;
    end else if (accept) begin
      counter <= counter_next;
      cur     <= cur_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bba_pixel_store.sv]
// Per-pixel colour memory: one read, one write a cycle, registered read.
// Fill mark stands in for reset-to-black; forwards a same-edge write.
// Depends on bba_pkg for COLOR_W.
`timescale 1ns / 1ps
`default_nettype none

module bba_pixel_store #(
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [bba_pkg::COLOR_W-1:0] wr_data,
  output logic      [bba_pkg::COLOR_W-1:0] rd_data
);
  import bba_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [COLOR_W-1:0] mem [DEPTH];
  logic [COLOR_W-1:0] rdata_q, fwd_q;
  logic               fwd_hit_q, filled_hit_q;
  logic [CW-1:0]      filled;  // entries below this have been written

  // writes walk up from zero, so the written set is always a prefix
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en && (CW'(wr_addr) == filled)) begin
      filled <= filled + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q      <= mem[rd_addr];
      fwd_q        <= wr_data;
      fwd_hit_q    <= wr_en && (wr_addr == rd_addr);
      filled_hit_q <= (CW'(rd_addr) < filled);
    end
  end

  assign rd_data = fwd_hit_q    ? fwd_q   :
                   filled_hit_q ? rdata_q : '0;

endmodule

`default_nettype wire

[rtl/core/bba_shader.sv]
// Colour pick for one pixel: bubble span, cleared gap, dice or stored colour.
// Depends on bba_pkg for cfg_t, pos_t and the dice codes.
`timescale 1ns / 1ps
`default_nettype none

module bba_shader #(
  parameter int IDX_W = 8
) (
  input  bba_pkg::cfg_t                    cfg,
  input  wire logic [IDX_W-1:0]            idx,
  input  bba_pkg::pos_t                    pos,
  input  wire logic [bba_pkg::DICE_W-1:0]  dice,
  input  wire logic [bba_pkg::COLOR_W-1:0] stored,
  output logic      [bba_pkg::COLOR_W-1:0] color
);
  import bba_pkg::*;

  logic signed [EXT_W-1:0] i, half, lead, trl, wid, spd, top, tail;
  logic                    hit, gap;

  always_comb begin
    i    = $signed(EXT_W'(idx));
    half = $signed(EXT_W'(cfg.midpoint));
    lead = EXT_W'($signed(pos.lead));
    trl  = EXT_W'($signed(pos.trail));
    wid  = $signed(EXT_W'(cfg.bubble_width));
    spd  = $signed(EXT_W'(cfg.bubble_speed));
    top  = lead - wid + EXT_W'(1);
    tail = trl + wid - EXT_W'(1);

    hit = ((i <= half) && (i <= lead) && (i >= top)) ||
          ((i > half) && (i >= trl) && (i <= tail));
    gap = !cfg.trail_mode &&
          (((i > lead) && (i <= lead + spd)) || ((i < trl) && (i >= trl - spd)));

    if (hit) begin
      color = cfg.bubble_color;
    end else if (gap) begin
      color = cfg.background_color_zero;
    end else begin
      case (dice)
        DICE_BG0: color = cfg.background_color_zero;
        DICE_BG1: color = cfg.background_colors_one_two[COLOR_W-1:0];
        DICE_BG2: color = cfg.background_colors_one_two[2*COLOR_W-1:COLOR_W];
        default:  color = stored;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/led_strip_bubble_animator.sv]
// Top level of the LED-strip bubble animator: handshake, pipeline registers.
// Depends on bba_pkg, bba_regs, bba_sequencer, bba_pixel_store, bba_shader.
//
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+---------------------------------
//  item     | item_valid / item_ready           | step_seen, dice
//  result   | result_valid / result_ready       | pixel_index, pixel_color, frame_last
//  config   | psel, penable, pwrite, pready = 1 | paddr (8-byte regs), pwdata, prdata
//
// One pixel per clock sustained while results are taken; the item transfer loads
// stage 1 (pixel store read on transfer), and the colour pick during stage 1 loads
// the result register. The registered colour memory read port is why stage 1 exists.
// Reset is synchronous; no clearing pass: a fill mark makes unwritten pixels
// read black. Result stalls back up through one internal stage to item_ready.
`timescale 1ns / 1ps
`default_nettype none

module led_strip_bubble_animator #(
  parameter int MAX_PIXELS = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bba_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [bba_pkg::DATA_W-1:0]    pwdata,
  output logic      [bba_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  // pixel items
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire logic                          step_seen,
  input  wire logic [bba_pkg::DICE_W-1:0]    dice,
  // pixel results
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic      [7:0]                    pixel_index,
  output logic      [bba_pkg::COLOR_W-1:0]   pixel_color,
  output logic                               frame_last
);
  import bba_pkg::*;

  localparam int IW = $clog2(MAX_PIXELS);

  cfg_t                cfg;
  logic                accept, out_free, s1_adv;
  logic [IW-1:0]       seq_idx;
  pos_t                seq_pos;
  logic                seq_last;

  // stage 1: item held while its stored colour is read
  logic                s1_valid;
  logic [IW-1:0]       s1_idx;
  pos_t                s1_pos;
  logic [DICE_W-1:0]   s1_dice;
  logic                s1_last;
  logic [COLOR_W-1:0]  stored, color;

  bba_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result register frees when empty or being taken
  assign out_free   = !result_valid || result_ready;
  assign s1_adv     = s1_valid && out_free;
  assign item_ready = !s1_valid || out_free;
  assign accept     = item_valid && item_ready;

  bba_sequencer #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .step_seen (step_seen),
    .idx       (seq_idx),
    .pos       (seq_pos),
    .last      (seq_last)
  );

  // read on transfer, write back when the pixel leaves stage 1
  bba_pixel_store #(
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (seq_idx),
    .wr_en   (s1_adv),
    .wr_addr (s1_idx),
    .wr_data (color),
    .rd_data (stored)
  );

  bba_shader #(
    .IDX_W (IW)
  ) u_shade (
    .cfg    (cfg),
    .idx    (s1_idx),
    .pos    (s1_pos),
    .dice   (s1_dice),
    .stored (stored),
    .color  (color)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx  <= seq_idx;
      s1_pos  <= seq_pos;
      s1_dice <= dice;
      s1_last <= seq_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      pixel_index <= 8'(s1_idx);
      pixel_color <= color;
      frame_last  <= s1_last;
    end
  end

`ifndef ASSERT_OFF
  // a new transfer never lands on a stage 1 pixel that cannot move on
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    accept && s1_valid |-> s1_adv)
    else $error("stage 1 overwritten");

  // the pixel after a frame's last one is pixel zero
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && seq_last |=> seq_idx == '0)
    else $error("frame did not wrap to pixel zero");

  // a stalled stage 1 keeps its pixel
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_idx) && $stable(s1_last))
    else $error("stage 1 lost its pixel under stall");
`endif

endmodule

`default_nettype wire
